/* rtl/deque_list_with_cursor_defines.svh */
// Assertion macros for the deque list with cursor
`ifndef DEQUE_LIST_WITH_CURSOR_DEFINES_SVH
`define DEQUE_LIST_WITH_CURSOR_DEFINES_SVH

`ifndef SYNTH
`define DLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DLC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DLC_ASSERT(lbl, prop, msg)
`define DLC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/dlc_pkg.sv */
// Shared types and constants for the deque list with cursor
package dlc_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned VALUE_W_DEF = 64;
  localparam int unsigned OPCODE_W    = 4;
  localparam int unsigned ITEM_W      = 64;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_TAIL     = 4'd0,
    OP_ADD_HEAD     = 4'd1,
    OP_REMOVE_VALUE = 4'd2,
    OP_REMOVE_HEAD  = 4'd3,
    OP_REMOVE_TAIL  = 4'd4,
    OP_FIRST        = 4'd5,
    OP_NEXT         = 4'd6,
    OP_CONTAINS     = 4'd7,
    OP_CLEAR        = 4'd8
  } opc_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } st_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ITEM_W-1:0]   item_value;
  } dlc_in_t;

  typedef struct packed {
    logic                   ok;
    logic [ITEM_W-1:0]      result_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
  } dlc_out_t;

  typedef struct packed {
    logic push;
    logic append;
    logic remove;
  } dlc_cmd_t;

endpackage

/* rtl/dlc_cell.sv */
// One list cell: holds an entry, compares it with the key and shifts with its neighbours
module dlc_cell #(
  parameter int unsigned VALUE_WIDTH = dlc_pkg::VALUE_W_DEF,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned CUR_W       = 7,
  parameter int unsigned INDEX       = 0
) (
  input  logic                   clk_i,
  input  dlc_pkg::dlc_cmd_t      cmd_i,
  input  logic                   cap_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic [VALUE_WIDTH-1:0] operand_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic                   del_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [CUR_W-1:0]       rd_idx_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   hit_o,
  output logic [VALUE_WIDTH-1:0] rd_o
);
  import dlc_pkg::*;

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   hit_q, hit_d;

  always_comb begin
    value_d = value_q;
    if (cmd_i.push) begin
      value_d = left_i;
    end else if (cmd_i.append && (count_i == CNT_W'(INDEX))) begin
      value_d = operand_i;
    end else if (cmd_i.remove && del_i) begin
      value_d = right_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (cap_i) begin
      hit_d = (CNT_W'(INDEX) < count_i) && (value_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    hit_q   <= hit_d;
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;
  assign rd_o    = (rd_idx_i == CUR_W'(INDEX)) ? value_q : '0;

endmodule

/* rtl/deque_list_with_cursor.sv */
// Top level of the deque list with cursor: control sequencer and the row of cells
//
// Usage:
//   Present a command on cmd_i (opcode and item_value) and raise start. The
//   command is taken at a rising edge where start is high and busy is low.
//   busy stays high while the command executes in the S_EXEC state.
//   Each command gives exactly one result on result_o (ok, result_value,
//   entry_count, is_empty), marked by done_o for a single cycle. done_o is
//   registered from the execution state. The receiver cannot stall the result:
//   it must take it in the cycle that done_o is high.
//   No command is taken while one executes. At the accept edge every cell
//   compares its entry with the key and the read entry is selected; in the
//   execution cycle the first match is resolved; push or remove shifts the row once.
//   A new command may be started in the cycle its predecessor's result shows.
//   Reset (rst_ni low, asynchronous) empties the list and clears the cursor;
//   entry contents are not cleared and are never observed before written.
module deque_list_with_cursor #(
  parameter int unsigned DEPTH       = dlc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = dlc_pkg::VALUE_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dlc_pkg::dlc_in_t  cmd_i,
  output logic              done_o,
  output dlc_pkg::dlc_out_t result_o
);
  import dlc_pkg::*;

  `include "deque_list_with_cursor_defines.svh"

  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned CUR_W   = $clog2(2 * DEPTH);
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CUR_MAX = 2 * DEPTH - 1;

  st_e                    state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CUR_W-1:0]       cur_q, cur_d;
  logic                   done_q, done_d;
  opc_e                   op_q;
  logic [VALUE_WIDTH-1:0] operand_q;
  logic [VALUE_WIDTH-1:0] rd_value_q, rd_value;
  dlc_out_t               res_q, res_d;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] key;
  logic [CUR_W-1:0]       rd_idx;
  dlc_cmd_t               cell_cmd;
  logic [DEPTH-1:0]       hits, hits_m1, below, first_hit, del_mask;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic                   ok;
  logic [VALUE_WIDTH-1:0] res_val;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  logic [VALUE_WIDTH-1:0] vals    [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_vals [DEPTH];

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign key    = cmd_i.item_value[VALUE_WIDTH-1:0];

  always_comb begin
    case (opc_e'(cmd_i.opcode))
      OP_REMOVE_TAIL: rd_idx = CUR_W'(cnt_q) - CUR_W'(1);
      OP_NEXT:        rd_idx = cur_q;
      default:        rd_idx = '0;
    endcase
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | rd_vals[i];
    end
  end

  assign hits_m1   = hits - DEPTH'(1);
  assign below     = ~hits & hits_m1;
  assign first_hit = hits & ~hits_m1;
  assign found     = |hits;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v, right_v;
    logic                   hit;

    if (g == 0) begin : g_head
      assign left_v = operand_q;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_v = vals[g];
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end

    dlc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W),
      .CUR_W      (CUR_W),
      .INDEX      (g)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cell_cmd),
      .cap_i    (accept),
      .key_i    (key),
      .operand_i(operand_q),
      .left_i   (left_v),
      .right_i  (right_v),
      .del_i    (del_mask[g]),
      .count_i  (cnt_q),
      .rd_idx_i (rd_idx),
      .value_o  (vals[g]),
      .hit_o    (hit),
      .rd_o     (rd_vals[g])
    );

    assign hits[g] = hit;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    done_d   = 1'b0;
    cell_cmd = '0;
    del_mask = '1;
    ok       = 1'b0;
    res_val  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (op_q)
          OP_ADD_TAIL: begin
            if (cnt_q != CNT_W'(DEPTH)) begin
              cell_cmd.append = 1'b1;
              cnt_d           = cnt_q + CNT_W'(1);
              ok              = 1'b1;
            end
          end
          OP_ADD_HEAD: begin
            if (cnt_q != CNT_W'(DEPTH)) begin
              cell_cmd.push = 1'b1;
              cnt_d         = cnt_q + CNT_W'(1);
              if ((cur_q != '0) && (cur_q < CUR_W'(CUR_MAX))) begin
                cur_d = cur_q + CUR_W'(1);
              end
              ok = 1'b1;
            end
          end
          OP_REMOVE_VALUE: begin
            del_mask = ~below;
            if (found) begin
              if ((cur_q != '0) && (CUR_W'(hit_idx) < cur_q)) begin
                cur_d = cur_q - CUR_W'(1);
              end
              cell_cmd.remove = 1'b1;
              cnt_d           = cnt_q - CNT_W'(1);
              ok              = 1'b1;
            end
          end
          OP_REMOVE_HEAD: begin
            if (cnt_q != '0) begin
              if (cur_q != '0) begin
                cur_d = cur_q - CUR_W'(1);
              end
              cell_cmd.remove = 1'b1;
              res_val         = rd_value_q;
              cnt_d           = cnt_q - CNT_W'(1);
              ok              = 1'b1;
            end
          end
          OP_REMOVE_TAIL: begin
            if (cnt_q != '0) begin
              if ((cur_q != '0) && (cur_q == (CUR_W'(cnt_q) - CUR_W'(1)))) begin
                cur_d = cur_q - CUR_W'(1);
              end
              res_val = rd_value_q;
              cnt_d   = cnt_q - CNT_W'(1);
              ok      = 1'b1;
            end
          end
          OP_FIRST: begin
            if (cnt_q == '0) begin
              cur_d = '0;
            end else begin
              cur_d   = CUR_W'(1);
              res_val = rd_value_q;
              ok      = 1'b1;
            end
          end
          OP_NEXT: begin
            if (cur_q < CUR_W'(cnt_q)) begin
              res_val = rd_value_q;
              cur_d   = cur_q + CUR_W'(1);
              ok      = 1'b1;
            end
          end
          OP_CONTAINS: begin
            if (found) begin
              cur_d = CUR_W'(hit_idx);
              ok    = 1'b1;
            end
          end
          OP_CLEAR: begin
            cnt_d = '0;
            cur_d = '0;
            ok    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_ext = (CNT_W + COUNT_OUT_W)'(cnt_d);

  always_comb begin
    res_d              = res_q;
    if (state_q == S_EXEC) begin
      res_d.ok           = ok;
      res_d.result_value = ITEM_W'(res_val);
      res_d.entry_count  = cnt_ext[COUNT_OUT_W-1:0];
      res_d.is_empty     = (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opc_e'(cmd_i.opcode);
      operand_q  <= key;
      rd_value_q <= rd_value;
    end
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `DLC_ASSERT(a_exec_done, (state_q == S_EXEC) |=> done_q, "execution gave no result")
  `DLC_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe held past one cycle")
  `DLC_ASSERT(a_hit_in_range, ((state_q == S_EXEC) && found) |-> (CNT_W'(hit_idx) < cnt_q), "match beyond list end")
  `DLC_ASSERT(a_cnt_step, ((state_q == S_EXEC) && (op_q != OP_CLEAR)) |=> ((cnt_q == $past(cnt_q)) || (cnt_q == ($past(cnt_q) + CNT_W'(1))) || (cnt_q == ($past(cnt_q) - CNT_W'(1)))), "count moved by more than one")
  `DLC_ASSERT_RST(a_reset_idle, !rst_ni |=> (!busy && !done_o), "busy or strobe during reset")

endmodule

/* test/deque_list_with_cursor_tb.sv */
// Self-checking testbench for the deque list with cursor, with a scoreboard class
module deque_list_with_cursor_tb;
  import dlc_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned CURSOR_TOP  = 2 * DEPTH - 1;
  localparam logic [3:0]  OP_SPARE_LO = 4'd9;
  localparam logic [3:0]  OP_SPARE_HI = 4'd15;
  localparam int unsigned GAP_CAP     = 12;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  dlc_in_t  cmd_i  = '0;
  logic     done_o;
  dlc_out_t result_o;

  int unsigned idle_pct;
  logic [63:0] value_pool [8];

  class deque_tracker;
    logic [63:0] entries [DEPTH];
    int unsigned count;
    int unsigned cursor;
    dlc_out_t    pending_results [$];
    int unsigned failures;

    function new();
      count    = 0;
      cursor   = 0;
      failures = 0;
    endfunction

    function int unsigned find_first(logic [63:0] v);
      for (int unsigned i = 0; i < count; i++) begin
        if (entries[i] == v) return i;
      end
      return count;
    endfunction

    function void delete_at(int unsigned idx);
      for (int unsigned i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
      count--;
    endfunction

    function void note_command(dlc_in_t c);
      dlc_out_t    r;
      logic [63:0] v;
      int unsigned idx;
      v = c.item_value;
      r = '0;
      case (c.opcode)
        OP_ADD_TAIL: begin
          if (count < DEPTH) begin
            entries[count] = v;
            count++;
            r.ok = 1'b1;
          end
        end
        OP_ADD_HEAD: begin
          if (count < DEPTH) begin
            for (int unsigned i = count; i > 0; i--) entries[i] = entries[i - 1];
            entries[0] = v;
            count++;
            if (cursor != 0 && cursor < CURSOR_TOP) cursor++;
            r.ok = 1'b1;
          end
        end
        OP_REMOVE_VALUE: begin
          idx = find_first(v);
          if (idx < count) begin
            if (cursor > 0 && idx < cursor) cursor--;
            delete_at(idx);
            r.ok = 1'b1;
          end
        end
        OP_REMOVE_HEAD: begin
          if (count > 0) begin
            if (cursor > 0) cursor--;
            r.result_value = entries[0];
            delete_at(0);
            r.ok = 1'b1;
          end
        end
        OP_REMOVE_TAIL: begin
          if (count > 0) begin
            if (cursor > 0 && cursor == count - 1) cursor--;
            r.result_value = entries[count - 1];
            count--;
            r.ok = 1'b1;
          end
        end
        OP_FIRST: begin
          if (count == 0) begin
            cursor = 0;
          end else begin
            cursor         = 1;
            r.result_value = entries[0];
            r.ok           = 1'b1;
          end
        end
        OP_NEXT: begin
          if (cursor < count) begin
            r.result_value = entries[cursor];
            cursor++;
            r.ok = 1'b1;
          end
        end
        OP_CONTAINS: begin
          idx = find_first(v);
          if (idx < count) begin
            cursor = idx;
            r.ok   = 1'b1;
          end
        end
        OP_CLEAR: begin
          count  = 0;
          cursor = 0;
          r.ok   = 1'b1;
        end
        default: begin
        end
      endcase
      r.entry_count = count[COUNT_OUT_W-1:0];
      r.is_empty    = (count == 0);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(dlc_out_t got);
      dlc_out_t want;
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending");
        failures++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
        failures++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %h, actual %h", want.result_value, got.result_value);
        failures++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        failures++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
        failures++;
      end
    endfunction
  endclass

  deque_tracker tracker = new();

  deque_list_with_cursor uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(result_o);
      if (start && !busy) tracker.note_command(cmd_i);
    end
  end

  function automatic logic [63:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  task automatic issue(input logic [3:0] opc, input logic [63:0] v);
    dlc_in_t     c;
    dlc_in_t     noise;
    int unsigned gap;
    c.opcode     = opc;
    c.item_value = v;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      noise.opcode     = 4'($urandom);
      noise.item_value = {$urandom, $urandom};
      start <= 1'b0;
      cmd_i <= noise;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_run(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned add_w;
    int unsigned r;
    logic [3:0]  opc;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(10, 40);
      if ($urandom_range(4) == 0) begin
        issue(OP_FIRST, pick_value());
        sent++;
        for (int unsigned k = 0; k < len && sent < n_items; k++) begin
          issue(OP_NEXT, pick_value());
          sent++;
        end
      end else begin
        case ($urandom_range(2))
          0:       add_w = 80;
          1:       add_w = 15;
          default: add_w = 45;
        endcase
        for (int unsigned k = 0; k < len && sent < n_items; k++) begin
          r = $urandom_range(99);
          if (r < add_w) opc = $urandom_range(1) ? OP_ADD_HEAD : OP_ADD_TAIL;
          else if (r > 96) opc = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
          else opc = 4'($urandom_range(OP_CLEAR, OP_REMOVE_VALUE));
          if (opc == OP_CLEAR && $urandom_range(3) != 0) opc = OP_NEXT;
          issue(opc, pick_value());
          sent++;
        end
      end
    end
  endtask

  // fill, walk to the end, pop the tail away and push heads so the cursor saturates
  task automatic cursor_overflow_run();
    issue(OP_CLEAR, pick_value());
    repeat (DEPTH) issue(OP_ADD_TAIL, pick_value());
    issue(OP_ADD_TAIL, pick_value());
    issue(OP_ADD_HEAD, pick_value());
    issue(OP_FIRST, pick_value());
    repeat (DEPTH) issue(OP_NEXT, pick_value());
    repeat (DEPTH) issue(OP_REMOVE_TAIL, pick_value());
    issue(OP_REMOVE_TAIL, pick_value());
    repeat (DEPTH) issue(OP_ADD_HEAD, pick_value());
    issue(OP_NEXT, pick_value());
    issue(OP_REMOVE_TAIL, pick_value());
    issue(OP_CONTAINS, value_pool[$urandom_range(7)]);
    issue(OP_NEXT, pick_value());
  endtask

  initial begin
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = {$urandom, $urandom};
    idle_pct = 34;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(OP_REMOVE_HEAD, 64'd0);
    issue(OP_REMOVE_TAIL, 64'd0);
    issue(OP_NEXT, 64'd0);
    issue(OP_FIRST, 64'd0);
    issue(OP_REMOVE_VALUE, 64'd0);
    issue(OP_CONTAINS, 64'd0);
    issue(OP_ADD_TAIL, 64'd0);
    issue(OP_ADD_TAIL, '1);
    issue(OP_ADD_HEAD, 64'h5555_5555_5555_5555);
    issue(OP_ADD_TAIL, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_FIRST, 64'd0);
    issue(OP_NEXT, 64'd0);
    issue(OP_NEXT, 64'd0);
    issue(OP_CONTAINS, '1);
    issue(OP_NEXT, 64'd0);
    issue(OP_NEXT, 64'd0);
    issue(OP_NEXT, 64'd0);
    issue(OP_ADD_HEAD, 64'd1);
    issue(OP_REMOVE_VALUE, 64'd0);
    issue(OP_REMOVE_TAIL, 64'd0);
    issue(OP_REMOVE_HEAD, 64'd0);
    issue(OP_SPARE_LO, '1);
    issue(OP_SPARE_HI, 64'd0);
    issue(OP_CLEAR, 64'd0);
    drain();

    random_run(70);
    drain();
    idle_pct = 48;
    random_run(70);
    drain();
    idle_pct = 0;
    cursor_overflow_run();
    random_run(20);
    drain();
    repeat (8) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
